// File: sv/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

    // Vertex space of the search
    localparam int MAX_VERTICES = 16;
    localparam int VERT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int STAMP_W      = 6;
    localparam int PARENT_W     = 5;

    // Parent code for a root
    localparam logic [PARENT_W-1:0] PARENT_NONE = PARENT_W'(MAX_VERTICES);

    // Input mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [VERT_W-1:0]       row_index;
        logic [MAX_VERTICES-1:0] row_edges;
    } in_t;

    typedef struct packed {
        logic [VERT_W-1:0]   vertex;
        logic                finished;
        logic [STAMP_W-1:0]  stamp;
        logic [PARENT_W-1:0] parent_vertex;
        logic                last;
    } out_t;

    // Result of the shared lowest-bit picker
    typedef struct packed {
        logic              found;
        logic [VERT_W-1:0] index;
    } pick_t;

endpackage

`default_nettype wire

// File: sv/dfs_pick.sv
`default_nettype none

module dfs_pick (
    input  wire logic [dfs_pkg::MAX_VERTICES-1:0] mask,
    output dfs_pkg::pick_t                        pick
);
    import dfs_pkg::*;

    logic [MAX_VERTICES-1:0] iso;
    logic [VERT_W-1:0]       index;

    // Isolate the lowest set bit, then encode its position
    always_comb
    begin
        iso   = mask & (~mask + MAX_VERTICES'(1));
        index = '0;
        for (int p = 0; p < MAX_VERTICES; p++)
        begin
            if (iso[p])
            begin
                index = index | VERT_W'(p);
            end
        end
    end

    assign pick.found = |mask;
    assign pick.index = index;

endmodule

`default_nettype wire

// File: sv/dfs_timestamp_walker.sv
`default_nettype none

// Depth-first search time stamper over up to 16 vertices. A load transaction
// (mode 0) writes one adjacency row. A run transaction (mode 1) walks the
// graph from roots in ascending order, always taking the lowest-numbered
// unvisited neighbor, and sends one output transaction per discover or
// finish event, with last set on the final one. A run of N vertices gives 2N
// events; the walker produces one event per cycle while the output is not
// stalled, and a single lowest-bit picker chooses both the next neighbor and
// the next root. Input is stalled for the whole run. A row must be loaded
// before any run reads it. The user must write vertex_count only while idle;
// the block itself does not enforce it. Values above 16 act as 16.
module dfs_timestamp_walker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire dfs_pkg::in_t                in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output dfs_pkg::out_t                    out_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [dfs_pkg::COUNT_W-1:0] cfg_wr_data
);
    import dfs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Control registers
    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [MAX_VERTICES-1:0] all_reg, all_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [COUNT_W-1:0]      depth_reg, depth_next;
    logic [STAMP_W-1:0]      time_reg, time_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_data_reg, out_data_next;

    // Register arrays
    logic [MAX_VERTICES-1:0] adj_reg    [MAX_VERTICES];
    logic [VERT_W-1:0]       stack_reg  [MAX_VERTICES];
    logic [PARENT_W-1:0]     parent_reg [MAX_VERTICES];

    logic                    in_accept;
    logic                    slot_free;
    logic                    stack_empty;
    logic [COUNT_W-1:0]      depth_m1;
    logic [VERT_W-1:0]       top_vertex;
    logic [MAX_VERTICES-1:0] cand_mask;
    pick_t                   pick;
    logic                    emit;
    logic                    push;
    logic [PARENT_W-1:0]     disc_parent;
    logic [COUNT_W-1:0]      n_sat;
    out_t                    event_data;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    // Read the top of the stack and form the candidate set
    assign stack_empty = (depth_reg == '0);
    assign depth_m1    = depth_reg - COUNT_W'(1);
    assign top_vertex  = stack_reg[depth_m1[VERT_W-1:0]];
    assign cand_mask   = (stack_empty ? all_reg : (adj_reg[top_vertex] & all_reg))
                         & ~visited_reg;
    assign disc_parent = stack_empty ? PARENT_NONE : {1'b0, top_vertex};
    assign n_sat       = (count_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                             : count_reg;

    dfs_pick u_pick (
        .mask (cand_mask),
        .pick (pick)
    );

    // Sequencer: one discover or finish event per step
    always_comb
    begin
        state_next     = state_reg;
        all_next       = all_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        time_next      = time_reg;
        emit           = 1'b0;
        push           = 1'b0;
        event_data     = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_data.mode == MODE_RUN))
                begin
                    state_next   = ST_RUN;
                    visited_next = '0;
                    depth_next   = '0;
                    time_next    = '0;
                    if (n_sat == COUNT_W'(MAX_VERTICES))
                    begin
                        all_next = '1;
                    end
                    else
                    begin
                        all_next = (MAX_VERTICES'(1) << n_sat) - MAX_VERTICES'(1);
                    end
                end
            end
            ST_RUN:
            begin
                if (stack_empty && !pick.found)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    emit      = 1'b1;
                    time_next = time_reg + STAMP_W'(1);
                    if (pick.found)
                    begin
                        // Discover the next vertex and push it
                        visited_next             = visited_reg
                                                   | (MAX_VERTICES'(1) << pick.index);
                        event_data.vertex        = pick.index;
                        event_data.finished      = 1'b0;
                        event_data.stamp         = time_next;
                        event_data.parent_vertex = disc_parent;
                        event_data.last          = 1'b0;
                        if (depth_reg < COUNT_W'(MAX_VERTICES))
                        begin
                            push       = 1'b1;
                            depth_next = depth_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        // Finish the top vertex and pop it
                        event_data.vertex        = top_vertex;
                        event_data.finished      = 1'b1;
                        event_data.stamp         = time_next;
                        event_data.parent_vertex = parent_reg[top_vertex];
                        event_data.last          = (depth_reg == COUNT_W'(1))
                                                   && ((visited_reg & all_reg) == all_reg);
                        depth_next               = depth_m1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load on a new event, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = event_data;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(MAX_VERTICES);
            all_reg       <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            all_reg       <= all_next;
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and array writes
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_accept && (in_data.mode == MODE_LOAD))
        begin
            adj_reg[in_data.row_index] <= in_data.row_edges;
        end
        if (push)
        begin
            stack_reg[depth_reg[VERT_W-1:0]] <= pick.index;
        end
        if (emit && pick.found)
        begin
            parent_reg[pick.index] <= disc_parent;
        end
    end

`ifndef SYNTHESIS
    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (depth_reg == '0))
        else $error("stack not empty while idle");

    a_last_empties_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && event_data.last) |=> (depth_reg == '0))
        else $error("last event left vertices on the stack");

    a_finish_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !pick.found) |-> visited_reg[top_vertex])
        else $error("finish of an unvisited vertex");

    a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (time_reg < STAMP_W'(2 * MAX_VERTICES)))
        else $error("time stamp beyond two events per vertex");
`endif

endmodule

`default_nettype wire
